### src/lz77_stream_decompressor_macros.svh
// Assertion macros for the LZ77 stream decompressor.
// Used by the top level; expects clk and rst_n in scope.
`ifndef LZ77_STREAM_DECOMPRESSOR_MACROS_SVH
`define LZ77_STREAM_DECOMPRESSOR_MACROS_SVH

// property must hold on every clock outside reset
`define LZSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define LZSD_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### src/lz77sd_pkg.sv
// Shared types and constants of the LZ77 stream decompressor.
// No dependencies; imported by the top level, the core and the output register.
package lz77sd_pkg;

  localparam int WINDOW_DEPTH_DEF = 4096;
  localparam int LENGTH_BITS_DEF  = 24;

  localparam logic [1:0] WW_BYTE = 2'd1;
  localparam logic [1:0] WW_HALF = 2'd2;

  localparam logic [1:0] NB_NONE = 2'd0;
  localparam logic [1:0] NB_ONE  = 2'd1;
  localparam logic [1:0] NB_TWO  = 2'd2;

  typedef struct packed {
    logic [15:0] data;
    logic [1:0]  nbytes;
    logic        last;
  } lz_res_t;

endpackage

### src/lz77_stream_decompressor.sv
// LZ77 stream decompressor, top level: config register, core, history, output stage.
// Output: outside half-word mode a literal shows on out_tdata in the cycle after its transfer.
// Throughput: one header, flag or literal byte per cycle while the output register
// has space; the second byte of a reference starts a copy that holds the input for
// a history read lead, then one byte per cycle from the read port while space lasts.
// Reset: synchronous active-low; parser idle, write_width = 1, history contents kept.
`include "lz77_stream_decompressor_macros.svh"
module lz77_stream_decompressor #(
  parameter int WINDOW_DEPTH = lz77sd_pkg::WINDOW_DEPTH_DEF,
  parameter int LENGTH_BITS  = lz77sd_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] stream_byte
  input  logic        in_tuser,   // [0] first
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] data
  output logic [1:0]  out_tuser,  // [1:0] bytes_valid
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data    // [1:0] write_width
);
  import lz77sd_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);

  logic [1:0]    ww_r;
  logic          space, push, busy;
  lz_res_t       res, out_res;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ww_r <= WW_BYTE;
    end else if (cfg_valid) begin
      ww_r <= cfg_data;
    end
  end

  lz77sd_core #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .LENGTH_BITS (LENGTH_BITS),
    .AW          (AW)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_first   (in_tuser),
    .write_width(ww_r),
    .res_space  (space),
    .res_push   (push),
    .res        (res),
    .busy       (busy),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  lz77sd_hist #(
    .DEPTH(WINDOW_DEPTH),
    .AW   (AW)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  lz77sd_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .res      (res),
    .space    (space),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (out_res)
  );

  assign out_tdata = out_res.data;
  assign out_tuser = out_res.nbytes;
  assign out_tlast = out_res.last;

  `LZSD_NEVER(a_no_accept_in_copy, in_tready && busy, "input taken during copy")
  `LZSD_NEVER(a_no_overwrite, push && out_tvalid && !out_tready, "result register overrun")
  `LZSD_ASSERT(a_empty_is_end, out_tvalid && out_tuser == NB_NONE |-> out_tlast && out_tdata == 16'h0000, "empty result not a zero end marker")
  `LZSD_ASSERT(a_byte_mode_high, push && res.nbytes == NB_ONE |-> res.data[15:8] == 8'h00, "byte result with high bits set")

endmodule

### src/lz77sd_hist.sv
// History window memory: one write port, one read port, registered read.
// Depends on nothing; instantiated by the top level.
module lz77sd_hist #(
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/lz77sd_obuf.sv
// Output result register between the decoder core and the master port.
// Depends on lz77sd_pkg.
module lz77sd_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lz77sd_pkg::lz_res_t res,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output lz77sd_pkg::lz_res_t out_res
);
  import lz77sd_pkg::*;

  logic    valid_r;
  lz_res_t res_r;

  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
    if (push) begin
      res_r <= res;
    end
  end

endmodule

### src/lz77sd_core.sv
// Stream parser and copy sequencer: header, flags, literals and references.
// Depends on lz77sd_pkg; drives the history memory and the output register.
module lz77sd_core #(
  parameter int WINDOW_DEPTH = lz77sd_pkg::WINDOW_DEPTH_DEF,
  parameter int LENGTH_BITS  = lz77sd_pkg::LENGTH_BITS_DEF,
  parameter int AW           = $clog2(WINDOW_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_first,
  input  logic [1:0]          write_width,
  input  logic                res_space,
  output logic                res_push,
  output lz77sd_pkg::lz_res_t res,
  output logic                busy,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [7:0]          ram_wdata,
  output logic                ram_re,
  output logic [AW-1:0]       ram_raddr,
  input  logic [7:0]          ram_rdata
);
  import lz77sd_pkg::*;

  typedef enum logic [3:0] {
    P_IDLE, P_LEN0, P_LEN1, P_LEN2, P_FLAGS, P_DATA, P_REF2, P_DONE, P_COPY
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [AW-1:0]        wp_r, wp_nxt;
  logic [LENGTH_BITS-1:0] left_r, left_nxt;
  logic [7:0]           flag_r, flag_nxt;
  logic [3:0]           fl_r, fl_nxt;
  logic [7:0]           ref_r, ref_nxt;
  logic [7:0]           low_r, low_nxt;
  logic                 par_r, par_nxt;
  logic [AW-1:0]        src_r, src_nxt;
  logic [4:0]           len_r, len_nxt;
  logic                 pend_r, pend_nxt;
  logic                 fwd_r, fwd_nxt;
  logic [7:0]           fwd_data_r, fwd_data_nxt;

  logic                   acc, prod_en, endb, nf;
  logic [7:0]             prod_b;
  logic [LENGTH_BITS-1:0] left_dec;
  logic [23:0]            len_full;
  logic [AW-1:0]          dist_m1;

  assign in_ready  = (phase_r != P_COPY) && res_space;
  assign busy      = (phase_r == P_COPY);
  assign acc       = in_valid && in_ready;
  assign prod_b    = (phase_r == P_COPY) ? (fwd_r ? fwd_data_r : ram_rdata) : in_byte;
  assign prod_en   = (acc && !in_first && phase_r == P_DATA && !flag_r[7]) ||
                     (phase_r == P_COPY && pend_r && res_space);
  assign left_dec  = left_r - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
  assign endb      = (left_dec == '0);
  assign len_full  = {in_byte, left_r[15:0]};
  assign dist_m1   = AW'({ref_r[3:0], in_byte});
  assign ram_waddr = wp_r;
  assign ram_wdata = prod_b;
  assign ram_raddr = src_r;

  always_comb begin
    phase_nxt    = phase_r;
    wp_nxt       = wp_r;
    left_nxt     = left_r;
    flag_nxt     = flag_r;
    fl_nxt       = fl_r;
    ref_nxt      = ref_r;
    low_nxt      = low_r;
    par_nxt      = par_r;
    src_nxt      = src_r;
    len_nxt      = len_r;
    pend_nxt     = pend_r;
    fwd_nxt      = fwd_r;
    fwd_data_nxt = fwd_data_r;
    res_push     = 1'b0;
    res          = '0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    nf           = 1'b0;

    if (prod_en) begin
      ram_we   = 1'b1;
      wp_nxt   = wp_r + {{(AW-1){1'b0}}, 1'b1};
      left_nxt = left_dec;
      if (write_width == WW_HALF) begin
        if (!par_r) begin
          low_nxt  = prod_b;
          par_nxt  = 1'b1;
          res_push = endb;
          res      = '{data: 16'h0000, nbytes: NB_NONE, last: 1'b1};
        end else begin
          par_nxt  = 1'b0;
          res_push = 1'b1;
          res      = '{data: {prod_b, low_r}, nbytes: NB_TWO, last: endb};
        end
      end else begin
        res_push = 1'b1;
        res      = '{data: {8'h00, prod_b}, nbytes: NB_ONE, last: endb};
      end
    end

    if (acc) begin
      if (in_first) begin
        left_nxt  = '0;
        flag_nxt  = '0;
        fl_nxt    = '0;
        ref_nxt   = '0;
        low_nxt   = '0;
        par_nxt   = 1'b0;
        phase_nxt = P_LEN0;
      end else begin
        case (phase_r)
          P_LEN0: begin
            left_nxt = LENGTH_BITS'(in_byte);
            phase_nxt = P_LEN1;
          end
          P_LEN1: begin
            left_nxt[15:8] = in_byte;
            phase_nxt = P_LEN2;
          end
          P_LEN2: begin
            left_nxt = len_full[LENGTH_BITS-1:0];
            if (len_full[LENGTH_BITS-1:0] == '0) begin
              res_push  = 1'b1;
              res       = '{data: 16'h0000, nbytes: NB_NONE, last: 1'b1};
              phase_nxt = P_DONE;
            end else begin
              phase_nxt = P_FLAGS;
            end
          end
          P_FLAGS: begin
            flag_nxt  = in_byte;
            fl_nxt    = 4'd8;
            phase_nxt = P_DATA;
          end
          P_DATA: begin
            if (flag_r[7]) begin
              ref_nxt   = in_byte;
              phase_nxt = P_REF2;
            end else begin
              nf = 1'b1;
            end
          end
          P_REF2: begin
            src_nxt   = wp_r - dist_m1 - {{(AW-1){1'b0}}, 1'b1};
            len_nxt   = {1'b0, ref_r[7:4]} + 5'd3;
            pend_nxt  = 1'b0;
            phase_nxt = P_COPY;
          end
          default: begin
          end
        endcase
      end
    end

    if (phase_r == P_COPY) begin
      if (!pend_r) begin
        ram_re   = 1'b1;
        src_nxt  = src_r + {{(AW-1){1'b0}}, 1'b1};
        pend_nxt = 1'b1;
        fwd_nxt  = 1'b0;
      end else if (res_space) begin
        len_nxt = len_r - 5'd1;
        if (endb || len_r == 5'd1) begin
          pend_nxt = 1'b0;
          nf       = 1'b1;
        end else begin
          ram_re       = 1'b1;
          src_nxt      = src_r + {{(AW-1){1'b0}}, 1'b1};
          fwd_nxt      = (src_r == wp_r);
          fwd_data_nxt = prod_b;
        end
      end
    end

    if (nf) begin
      flag_nxt = {flag_r[6:0], 1'b0};
      fl_nxt   = fl_r - {3'b000, (fl_r != 4'd0)};
      if (prod_en && endb) begin
        phase_nxt = P_DONE;
      end else if (fl_nxt == 4'd0) begin
        phase_nxt = P_FLAGS;
      end else begin
        phase_nxt = P_DATA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      wp_r    <= '0;
      left_r  <= '0;
      flag_r  <= '0;
      fl_r    <= '0;
      ref_r   <= '0;
      low_r   <= '0;
      par_r   <= 1'b0;
      pend_r  <= 1'b0;
      fwd_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      wp_r    <= wp_nxt;
      left_r  <= left_nxt;
      flag_r  <= flag_nxt;
      fl_r    <= fl_nxt;
      ref_r   <= ref_nxt;
      low_r   <= low_nxt;
      par_r   <= par_nxt;
      pend_r  <= pend_nxt;
      fwd_r   <= fwd_nxt;
    end
    src_r      <= src_nxt;
    len_r      <= len_nxt;
    fwd_data_r <= fwd_data_nxt;
  end

endmodule
